// File: hdl/glb_pkg.sv
// shared types, constants and the gaussian weight table of the line blur
`timescale 1ns / 1ps

package glb_pkg;

    localparam int MAX_RADIUS = 25;
    localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int MEM_AW     = $clog2(WIN_DEPTH);
    localparam int MEM_DEPTH  = 2 ** MEM_AW;
    localparam int RAD_W      = 5;
    localparam int CNT_W      = 6;
    localparam int WT_W       = 17;
    localparam int ACC_W      = 26;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int PADDR_W    = 3;

    // register index, taken from paddr[2]
    localparam logic REG_BLUR_RADIUS = 1'b0;

    typedef struct packed {
        logic [7:0] pixel;
        logic       line_end;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic             load;
        logic             last;
        logic [CNT_W-1:0] pend;
    } t_eng_stat;

    typedef logic [MAX_RADIUS:0][MAX_RADIUS:0][WT_W-1:0] t_wtab;

    // shift-subtract division, elaboration only
    function automatic logic [63:0] f_div(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] rem;
        int          i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(-f), f in q16, result in q30
    function automatic logic [63:0] f_exp_neg(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        int          n;
        term = 64'd1 << 30;
        pos  = 64'd1 << 30;
        neg  = '0;
        for (n = 1; n <= 16; n++) begin
            term = f_div(term * f, 64'd65536 * 64'(n));
            if (n % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return pos - neg;
    endfunction

    function automatic t_wtab f_build_weights();
        t_wtab       tab;
        logic [63:0] g [0:MAX_RADIUS];
        logic [63:0] e1;
        logic [63:0] s;
        logic [63:0] sum;
        logic [63:0] a;
        logic [63:0] k;
        logic [63:0] v;
        int          rad;
        int          r;
        int          j;
        tab = '0;
        e1  = f_exp_neg(64'd65536);
        tab[0][0] = WT_W'(65536);
        for (rad = 1; rad <= MAX_RADIUS; rad++) begin
            s   = 64'd3 * 64'(rad) + 64'd6;
            sum = '0;
            for (r = 0; r <= MAX_RADIUS; r++) begin
                g[r] = '0;
            end
            for (r = 0; r <= rad; r++) begin
                a = f_div(64'd50 * 64'(r) * 64'(r) * 64'd65536, s * s);
                k = a >> 16;
                v = f_exp_neg(a & 64'hFFFF);
                for (j = 0; j < 8; j++) begin
                    if (64'(j) < k && v != 0) begin
                        v = (v * e1) >> 30;
                    end
                end
                g[r] = v;
                sum  = sum + ((r == 0) ? v : 2 * v);
            end
            for (r = 0; r <= rad; r++) begin
                tab[rad][r] = WT_W'(f_div(g[r] * 64'd65536 + (sum >> 1), sum));
            end
        end
        return tab;
    endfunction

    localparam t_wtab W_TAB = f_build_weights();

endpackage

// File: hdl/glb_front.sv
// input side: accepts pixel transactions into a short queue
`timescale 1ns / 1ps

module glb_front
    import glb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_pixel_in,
    input  logic       i_line_end,
    output logic       o_stall,
    output t_item      o_item,
    output logic       o_q_valid,
    input  logic       i_pop,
    output t_q_stat    o_stat
);

    t_item          r_q [0:QDEPTH-1];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic           push;
    logic           pop;

    assign o_stall   = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign push      = i_valid && !o_stall;
    assign pop       = i_pop && o_q_valid;
    assign o_item    = r_q[r_rd];
    assign o_stat    = '{full: o_stall, empty: !o_q_valid};

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{pixel: i_pixel_in, line_end: i_line_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/glb_back.sv
// filter engine: line window memory, tap sequencer, multiply-accumulate, output register
`timescale 1ns / 1ps

module glb_back
    import glb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  logic             i_q_valid,
    output logic             o_pop,
    input  logic [RAD_W-1:0] i_radius,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_pixel_out,
    output logic             o_last_of_line,
    output t_eng_stat        o_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TAP,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state            r_state;
    logic [7:0]        r_mem [0:MEM_DEPTH-1];
    logic [MEM_AW-1:0] r_wp;
    logic [CNT_W-1:0]  r_lp;
    logic [CNT_W-1:0]  r_pend;
    logic              r_end;
    logic [RAD_W-1:0]  r_rad;
    logic signed [5:0] r_k;
    logic [CNT_W-1:0]  r_d;
    logic [ACC_W-1:0]  r_acc;
    logic              r_mv;
    logic [WT_W-1:0]   r_wt;
    logic [7:0]        r_rdata;
    logic              r_ovalid;
    logic [7:0]        r_opix;
    logic              r_olast;

    logic [RAD_W-1:0]  rad_sat;
    logic signed [7:0] ofs;
    logic [CNT_W-1:0]  ofs_lo;
    logic [CNT_W-1:0]  pos_max;
    logic [CNT_W-1:0]  ofs_hi;
    logic [MEM_AW-1:0] ofs_cl;
    logic [MEM_AW-1:0] rd_addr;
    logic [RAD_W-1:0]  tap_dist;
    logic [WT_W-1:0]   weight;
    logic              out_free;
    logic              emit_now;
    logic              last_tap;
    logic [ACC_W-1:0]  acc_sum;
    logic [7:0]        sat_pix;
    logic              load;

    assign rad_sat  = (i_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : i_radius;
    // tap offset behind newest pixel, clamped to the line and the window
    assign ofs      = $signed({2'b00, r_d}) - $signed({{2{r_k[5]}}, r_k});
    assign ofs_lo   = ofs[7] ? '0 : ofs[CNT_W-1:0];
    assign pos_max  = r_lp - 1'b1;
    assign ofs_hi   = (ofs_lo > pos_max) ? pos_max : ofs_lo;
    assign ofs_cl   = (ofs_hi > CNT_W'(WIN_DEPTH - 1)) ? MEM_AW'(WIN_DEPTH - 1)
                                                        : ofs_hi[MEM_AW-1:0];
    assign rd_addr  = r_wp - 1'b1 - ofs_cl;
    assign tap_dist = r_k[5] ? RAD_W'(-r_k) : RAD_W'(r_k);
    assign weight   = W_TAB[r_rad][tap_dist];
    assign out_free = !r_ovalid || !i_stall;
    assign emit_now = r_end ? (r_pend != '0) : (r_pend > CNT_W'(r_rad));
    assign last_tap = (r_k == $signed({1'b0, r_rad}));
    assign acc_sum  = r_acc + ACC_W'(r_rdata * r_wt);
    assign sat_pix  = (r_acc[ACC_W-1:16] > (ACC_W-16)'(255)) ? 8'd255 : r_acc[23:16];
    assign load     = (r_state == S_FIN) && out_free;

    assign o_pop          = (r_state == S_IDLE) && i_q_valid;
    assign o_valid        = r_ovalid;
    assign o_pixel_out    = r_opix;
    assign o_last_of_line = r_olast;
    assign o_stat         = '{load: load, last: r_end && (r_d == '0), pend: r_pend};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mem[r_wp] <= i_item.pixel;
        end
        r_rdata <= r_mem[rd_addr];
        r_wt    <= weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_lp     <= '0;
            r_pend   <= '0;
            r_end    <= 1'b0;
            r_rad    <= '0;
            r_k      <= '0;
            r_d      <= '0;
            r_acc    <= '0;
            r_mv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_opix   <= '0;
            r_olast  <= 1'b0;
        end else begin
            r_mv <= (r_state == S_TAP);
            if (r_mv) begin
                r_acc <= acc_sum;
            end
            if (!i_stall && !load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_wp  <= r_wp + 1'b1;
                        r_end <= i_item.line_end;
                        r_rad <= rad_sat;
                        if (r_lp != '1) begin
                            r_lp <= r_lp + 1'b1;
                        end
                        if (r_pend != '1) begin
                            r_pend <= r_pend + 1'b1;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (emit_now) begin
                        r_d     <= r_pend - 1'b1;
                        r_k     <= $signed(~{1'b0, r_rad}) + 6'sd1;
                        r_acc   <= '0;
                        r_state <= S_TAP;
                    end else begin
                        if (r_end) begin
                            r_lp <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_TAP: begin
                    r_k <= r_k + 6'sd1;
                    if (last_tap) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_opix   <= sat_pix;
                        r_olast  <= r_end && (r_d == '0);
                        r_pend   <= r_pend - 1'b1;
                        r_state  <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/gaussian_line_blur_clamped_core.sv
// top level of the clamped-edge gaussian line blur with its register port
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// pixel in  input      i_valid / o_stall    i_pixel_in, i_line_end
// pixel out output     o_valid / i_stall    o_pixel_out, o_last_of_line
// register  apb        psel/penable/pready  paddr, pwdata, prdata (blur_radius at 0x0)
//
// an input transaction that releases no pixel only passes the engine's idle and check states;
// each released pixel takes 2R+1 taps through the one multiplier,
// one pipeline drain, one load of the output register and one decision step
// a four-entry queue in front keeps accepting while the engine works
// reset is synchronous, active low; blur_radius resets to 1, window memory is
// not cleared (entries are always written before they are read)
// a stalled output holds the engine in its load step, the queue then fills up

module gaussian_line_blur_clamped_core
    import glb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_pixel_in,
    input  logic               i_line_end,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_pixel_out,
    output logic               o_last_of_line,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [RAD_W-1:0] r_radius;
    t_item            q_item;
    logic             q_valid;
    logic             q_pop;
    t_q_stat          q_stat;
    t_eng_stat        eng_stat;
    logic             cfg_wr;

    // register file: a single radius register where paddr[2] is clear, addresses with paddr[2] set are ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_BLUR_RADIUS) ? {{(32-RAD_W){1'b0}}, r_radius} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_W'(1);
        end else if (cfg_wr && (paddr[2] == REG_BLUR_RADIUS)) begin
            r_radius <= pwdata[RAD_W-1:0];
        end
    end

    // front: accepts pixel transactions into the queue
    glb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_pixel_in (i_pixel_in),
        .i_line_end (i_line_end),
        .o_stall    (o_stall),
        .o_item     (q_item),
        .o_q_valid  (q_valid),
        .i_pop      (q_pop),
        .o_stat     (q_stat)
    );

    // back: window memory and sequential multiply-accumulate over the taps
    glb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (q_item),
        .i_q_valid      (q_valid),
        .o_pop          (q_pop),
        .i_radius       (r_radius),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_out    (o_pixel_out),
        .o_last_of_line (o_last_of_line),
        .o_stat         (eng_stat)
    );

    // queue status flags never both set
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // a result is loaded only when the output register is free or being taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_stat.load |-> (!o_valid || !i_stall))
        else $error("output register overwritten");

    // the last pixel of a line is loaded while it is the only pending pixel
    a_last_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eng_stat.load && eng_stat.last) |-> (eng_stat.pend == CNT_W'(1)))
        else $error("last of line with pixels still pending");

endmodule

// File: tb/sv/tb_gaussian_line_blur_clamped_core.sv
// self-checking testbench for the clamped-edge gaussian line blur core
`timescale 1ns / 1ps

module tb_gaussian_line_blur_clamped_core;
    import glb_pkg::*;

    // register index with no register behind it, must be ignored
    localparam int UNUSED_REG_INDEX = 1;
    // cycles with no transaction on either channel before the run is abandoned
    localparam int STALL_LIMIT = 4000;
    // extra cycles the engine may still work after the last blurred pixel
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } t_blurred;

    // blur predictor plus the queue of blurred pixels still owed by the core
    class blur_scoreboard;
        int unsigned wt [0:MAX_RADIUS][0:MAX_RADIUS];
        logic [7:0]  line_pixels [0:WIN_DEPTH-1];
        int unsigned pending;
        int unsigned line_pos;
        int unsigned radius;
        int          mismatches;
        t_blurred    owed [$];

        // e^(-f) in q30 from a series through the 16th-order term, f in q16
        function longint unsigned exp_neg(longint unsigned f);
            longint unsigned term;
            longint unsigned pos;
            longint unsigned neg;
            term = longint'(1) << 30;
            pos  = term;
            neg  = 0;
            for (int n = 1; n <= 16; n++) begin
                term = (term * f) / (longint'(65536) * n);
                if (n % 2 == 1) begin
                    neg += term;
                end else begin
                    pos += term;
                end
            end
            return pos - neg;
        endfunction

        function new();
            longint unsigned g [0:MAX_RADIUS];
            longint unsigned e1;
            longint unsigned s;
            longint unsigned sum;
            longint unsigned a;
            longint unsigned k;
            longint unsigned v;
            e1 = exp_neg(65536);
            foreach (wt[i, j]) wt[i][j] = 0;
            wt[0][0] = 65536;
            for (int rad = 1; rad <= MAX_RADIUS; rad++) begin
                s   = 3 * rad + 6;
                sum = 0;
                for (int r = 0; r <= rad; r++) begin
                    a = (longint'(50) * r * r * 65536) / (s * s);
                    k = a >> 16;
                    v = exp_neg(a & 'hFFFF);
                    while (k > 0 && v != 0) begin
                        v = (v * e1) >> 30;
                        k--;
                    end
                    g[r] = v;
                    sum += (r == 0) ? v : 2 * v;
                end
                for (int r = 0; r <= rad; r++) begin
                    wt[rad][r] = (g[r] * 65536 + sum / 2) / sum;
                end
            end
            foreach (line_pixels[i]) line_pixels[i] = '0;
            pending    = 0;
            line_pos   = 0;
            radius     = 1;
            mismatches = 0;
        endfunction

        function void set_register(int index, logic [31:0] value);
            if (index == int'(REG_BLUR_RADIUS)) radius = value[4:0];
        endfunction

        // blurred pixel centered d places behind the newest, p = newest position in line
        function logic [7:0] blur_pixel(int d, int rad, int p);
            int unsigned acc;
            int          o;
            if (rad == 0) return (d < WIN_DEPTH) ? line_pixels[d] : 8'd0;
            acc = 0;
            for (int k = -rad; k <= rad; k++) begin
                o = d - k;
                if (o < 0) o = 0;
                if (o > p) o = p;
                if (o >= WIN_DEPTH) o = WIN_DEPTH - 1;
                acc += line_pixels[o] * wt[rad][(k < 0) ? -k : k];
            end
            acc = acc >> 16;
            return (acc > 255) ? 8'd255 : acc[7:0];
        endfunction

        function void note_pixel(logic [7:0] pixel, logic line_end);
            int rad;
            int p;
            rad = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
            for (int i = WIN_DEPTH - 1; i > 0; i--) line_pixels[i] = line_pixels[i-1];
            line_pixels[0] = pixel;
            if (line_pos < 63) line_pos++;
            if (pending < 63) pending++;
            p = line_pos - 1;
            // line end flushes everything held back, otherwise keep R pixels back
            while (pending > (line_end ? 0 : rad)) begin
                owed.push_back({blur_pixel(pending - 1, rad, p), line_end && pending == 1});
                pending--;
            end
            if (line_end) line_pos = 0;
        endfunction

        function void check_pixel(logic [7:0] pixel, logic last);
            t_blurred want;
            if (owed.size() == 0) begin
                if (mismatches < 10) $display("unexpected pixel %0d last %0b", pixel, last);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (want.pixel !== pixel || want.last !== last) begin
                if (mismatches < 10)
                    $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                             want.pixel, want.last, pixel, last);
                mismatches++;
            end
        endfunction

        function int owed_count();
            return owed.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_pixel_in;
    logic               i_line_end;
    logic               o_valid;
    logic               i_stall;
    logic [7:0]         o_pixel_out;
    logic               o_last_of_line;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    blur_scoreboard sb;
    int             idle_cycles;
    int             burst_left;
    bit             long_hold;

    gaussian_line_blur_clamped_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_in     (i_pixel_in),
        .i_line_end     (i_line_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_out    (o_pixel_out),
        .o_last_of_line (o_last_of_line),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // monitor: check blurred pixels, then record accepted input pixels
    // an output can never come from an input taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_pixel(o_pixel_out, o_last_of_line);
            if (i_valid && !o_stall) sb.note_pixel(i_pixel_in, i_line_end);
            // watchdog on cycles with no transaction at all
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // receiver: stall patterns in chunks, or one long hold to fill the core
    initial begin
        int mode;
        i_stall <= 1'b0;
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                repeat (24) begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(0, 2) == 0);
                        2: i_stall <= ~i_stall;
                        default: i_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // apb write: setup cycle, then access cycle
    task automatic reg_write(int index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(index, value);
    endtask

    // one pixel transaction, sender idles between bursts of random length
    task automatic send_pixel(logic [7:0] pixel, logic line_end);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= pixel;
        i_line_end <= line_end;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
    endtask

    // stop offering and let every owed pixel come out, then let the engine settle
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        // wait for an edge first so the last accepted transaction is on record
        @(posedge i_clk);
        while (sb.owed_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_line(int len, logic [7:0] fill);
        for (int i = 0; i < len; i++) send_pixel(fill, i == len - 1);
    endtask

    // random lines, mostly short, some long enough to saturate the position count
    task automatic random_phase(int count);
        int       len;
        int       sent;
        int       style;
        logic [7:0] pixel;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0, 1:    len = $urandom_range(13, 40);
                2:       len = $urandom_range(55, 70);
                default: len = $urandom_range(1, 12);
            endcase
            style = $urandom_range(0, 4);
            for (int i = 0; i < len; i++) begin
                // sometimes leave the line open across a radius change
                if (sent >= count && $urandom_range(0, 2) == 0) return;
                case (style)
                    0:       pixel = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    1:       pixel = 8'd255;
                    default: pixel = 8'($urandom_range(0, 255));
                endcase
                send_pixel(pixel, i == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        int radii [10] = '{31, 25, 0, 2, 5, 9, 17, 3, 12, 1};
        sb          = new();
        idle_cycles = 0;
        burst_left  = 0;
        long_hold   = 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pixel_in  <= '0;
        i_line_end  <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset radius, one-pixel line, extremes, saturation
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_line(4, 8'd255);
        drain();
        // pass-through at radius zero
        reg_write(REG_BLUR_RADIUS, 32'd0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd255, 1'b1);
        drain();
        // widest kernel on short lines
        reg_write(REG_BLUR_RADIUS, 32'd25);
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd250, 1'b1);
        drain();
        // radius shrinks mid-line: surplus comes out on the next pixel
        reg_write(REG_BLUR_RADIUS, 32'd6);
        for (int i = 0; i < 5; i++) send_pixel(8'($urandom_range(0, 255)), 1'b0);
        drain();
        reg_write(REG_BLUR_RADIUS, 32'd2);
        send_pixel(8'd99, 1'b0);
        send_pixel(8'd1, 1'b1);
        drain();
        // write to an unused index must leave the radius alone
        reg_write(UNUSED_REG_INDEX, 32'hFFFF_FFE0 | $urandom_range(0, 31));
        send_line(3, 8'd77);
        drain();

        foreach (radii[i]) begin
            reg_write(REG_BLUR_RADIUS,
                      {27'($urandom_range(0, 'h7FF_FFFF)), radii[i][4:0]});
            // long receiver hold while the sender keeps offering
            if (i == 3) long_hold = 1'b1;
            random_phase(15);
            drain();
        end

        if (sb.mismatches == 0 && sb.owed_count() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (sb.owed_count() != 0) $display("%0d blurred pixels never arrived", sb.owed_count());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/glb_pkg.sv
hdl/glb_front.sv
hdl/glb_back.sv
hdl/gaussian_line_blur_clamped_core.sv
tb/sv/tb_gaussian_line_blur_clamped_core.sv
